// ----- hdl/yuvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// shared register codes, reset values and color conversion helpers
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

  localparam int unsigned CFG_DW = 13;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_DW-1:0] SRC_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DW-1:0] SRC_HEIGHT_RST = 13'd480;
  localparam logic [CFG_DW-1:0] DST_WIDTH_RST  = 13'd96;
  localparam logic [CFG_DW-1:0] DST_HEIGHT_RST = 13'd96;

  typedef logic signed [20:0] csum_t;

  localparam csum_t K_Y    = 21'sd298;
  localparam csum_t K_RV   = 21'sd409;
  localparam csum_t K_GU   = 21'sd100;
  localparam csum_t K_GV   = 21'sd208;
  localparam csum_t K_BU   = 21'sd516;
  localparam csum_t ROUND  = 21'sd128;
  localparam logic signed [9:0] OFS_Y = 10'sd16;
  localparam logic signed [9:0] OFS_C = 10'sd128;

  // round, drop eight fraction bits, clamp to a byte
  function automatic logic [7:0] to_byte(input csum_t s);
    csum_t       t;
    logic [12:0] v;
    t = s + ROUND;
    v = t[20:8];
    if (t < 0) begin
      return 8'd0;
    end else if (v > 13'd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

endpackage

// ----- hdl/yuv_scale_to_rgb_top.sv -----
// ----------------------------------------------------------------------------
// yuv_scale_to_rgb_top
// nearest-neighbor downscaler with BT.601 YUV to RGB conversion
// ----------------------------------------------------------------------------
// Source pixels arrive in raster order, one word per cycle unless the input
// stalls. A word is taken when offered while the dividers are idle and the
// pipeline can advance; selected ones pass through the input register stage
// and the result register. Selection counters step floor(i*src/dst) with a
// quotient and remainder per axis; these two divisions run on two bit-serial
// dividers, $clog2(MAX_DIMENSION+1) bits wide. After reset and after every
// configuration write the input stalls while the dividers run.
// tuser on the input is frame_start, tlast on the output is frame_last.
// ----------------------------------------------------------------------------
module yuv_scale_to_rgb_top #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [yuvrgb_pkg::CFG_DW-1:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // luma, chroma_blue, chroma_red
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // red, green, blue, dest_column, dest_row
  output logic        out_tlast
);

  import yuvrgb_pkg::*;

  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int CW = $clog2(MAX_DIMENSION);
  localparam int TW = DW + 1;
  localparam int EW = (DW > CFG_DW) ? DW : CFG_DW;
  localparam logic [DW-1:0] MAX_DIM = DW'(MAX_DIMENSION);

  // configuration
  logic [CFG_DW-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic              start_r;
  logic              cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SRC_WIDTH_RST;
      src_h_r <= SRC_HEIGHT_RST;
      dst_w_r <= DST_WIDTH_RST;
      dst_h_r <= DST_HEIGHT_RST;
      start_r <= 1'b1;
    end else begin
      start_r <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SRC_WIDTH:  src_w_r <= cfg_data;
          REG_SRC_HEIGHT: src_h_r <= cfg_data;
          REG_DST_WIDTH:  dst_w_r <= cfg_data;
          REG_DST_HEIGHT: dst_h_r <= cfg_data;
        endcase
      end
    end
  end

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_DW-1:0] v,
                                            input logic [DW-1:0] hi);
    if (v == '0) begin
      return DW'(1);
    end else if (EW'(v) > EW'(hi)) begin
      return hi;
    end else begin
      return DW'(v);
    end
  endfunction

  logic [DW-1:0] sw_c, sh_c, tw_c, th_c;
  logic [DW-1:0] sw_r, sh_r, tw_r, th_r;

  always_comb begin
    sw_c = eff_dim(src_w_r, MAX_DIM);
    sh_c = eff_dim(src_h_r, MAX_DIM);
    tw_c = eff_dim(dst_w_r, sw_c);
    th_c = eff_dim(dst_h_r, sh_c);
  end

  always_ff @(posedge clk) begin
    if (start_r) begin
      sw_r <= sw_c;
      sh_r <= sh_c;
      tw_r <= tw_c;
      th_r <= th_c;
    end
  end

  logic          cdiv_busy, rdiv_busy, busy;
  logic [DW-1:0] cq, cr, rq, rr;

  yuvrgb_div #(.W(DW)) u_col_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (sw_c),
    .divisor   (tw_c),
    .busy      (cdiv_busy),
    .quotient  (cq),
    .remainder (cr)
  );

  yuvrgb_div #(.W(DW)) u_row_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (sh_c),
    .divisor   (th_c),
    .busy      (rdiv_busy),
    .quotient  (rq),
    .remainder (rr)
  );

  assign busy = start_r || cdiv_busy || rdiv_busy;

  // handshake
  logic s1_valid_r, out_valid_r;
  logic out_adv, s1_adv, in_fire;

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign in_tready = !busy && s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // position counters
  logic [CW-1:0] scol_r, srow_r;
  logic [TW-1:0] ctgt_r, rtgt_r;
  logic [DW-1:0] crem_r, rrem_r, tci_r, tri_r;
  logic          done_r;

  logic [CW-1:0] scol_nxt, srow_nxt, b_scol, b_srow;
  logic [TW-1:0] ctgt_nxt, rtgt_nxt, b_ctgt, b_rtgt;
  logic [DW-1:0] crem_nxt, rrem_nxt, tci_nxt, tri_nxt, b_crem, b_rrem, b_tci, b_tri;
  logic          done_nxt, b_done, sel, last;
  logic [DW:0]   csum, rsum;

  always_comb begin
    if (in_tuser) begin
      b_scol = '0; b_srow = '0; b_ctgt = '0; b_rtgt = '0;
      b_crem = '0; b_rrem = '0; b_tci = '0; b_tri = '0; b_done = 1'b0;
    end else begin
      b_scol = scol_r; b_srow = srow_r; b_ctgt = ctgt_r; b_rtgt = rtgt_r;
      b_crem = crem_r; b_rrem = rrem_r; b_tci = tci_r; b_tri = tri_r; b_done = done_r;
    end

    sel  = !b_done && (TW'(b_srow) == b_rtgt) && (TW'(b_scol) == b_ctgt)
           && (b_tri < th_r) && (b_tci < tw_r);
    last = (b_tri == th_r - 1'b1) && (b_tci == tw_r - 1'b1);

    scol_nxt = b_scol; srow_nxt = b_srow; ctgt_nxt = b_ctgt; rtgt_nxt = b_rtgt;
    crem_nxt = b_crem; rrem_nxt = b_rrem; tci_nxt = b_tci; tri_nxt = b_tri;
    done_nxt = b_done;

    csum = {1'b0, b_crem} + {1'b0, cr};
    rsum = {1'b0, b_rrem} + {1'b0, rr};

    if (sel) begin
      done_nxt = b_done || last;
      tci_nxt  = b_tci + 1'b1;
      if (csum >= {1'b0, tw_r}) begin
        crem_nxt = DW'(csum - {1'b0, tw_r});
        ctgt_nxt = b_ctgt + TW'(cq) + 1'b1;
      end else begin
        crem_nxt = DW'(csum);
        ctgt_nxt = b_ctgt + TW'(cq);
      end
    end

    if (DW'(b_scol) + 1'b1 >= sw_r) begin
      scol_nxt = '0; ctgt_nxt = '0; crem_nxt = '0; tci_nxt = '0;
      if (DW'(b_srow) + 1'b1 >= sh_r) begin
        srow_nxt = '0; rtgt_nxt = '0; rrem_nxt = '0; tri_nxt = '0;
        done_nxt = 1'b0;
      end else begin
        if (TW'(b_srow) == b_rtgt) begin
          tri_nxt = b_tri + 1'b1;
          if (rsum >= {1'b0, th_r}) begin
            rrem_nxt = DW'(rsum - {1'b0, th_r});
            rtgt_nxt = b_rtgt + TW'(rq) + 1'b1;
          end else begin
            rrem_nxt = DW'(rsum);
            rtgt_nxt = b_rtgt + TW'(rq);
          end
        end
        srow_nxt = b_srow + 1'b1;
      end
    end else begin
      scol_nxt = b_scol + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scol_r <= '0; srow_r <= '0; ctgt_r <= '0; rtgt_r <= '0;
      crem_r <= '0; rrem_r <= '0; tci_r <= '0; tri_r <= '0; done_r <= 1'b0;
    end else if (in_fire) begin
      scol_r <= scol_nxt; srow_r <= srow_nxt; ctgt_r <= ctgt_nxt; rtgt_r <= rtgt_nxt;
      crem_r <= crem_nxt; rrem_r <= rrem_nxt; tci_r <= tci_nxt; tri_r <= tri_nxt;
      done_r <= done_nxt;
    end
  end

  // input register stage
  logic [7:0]  s1_y_r, s1_u_r, s1_v_r;
  logic [11:0] s1_col_r, s1_row_r;
  logic        s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_fire && sel;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_fire && sel) begin
      s1_y_r    <= in_tdata[7:0];
      s1_u_r    <= in_tdata[15:8];
      s1_v_r    <= in_tdata[23:16];
      s1_col_r  <= 12'(b_tci);
      s1_row_r  <= 12'(b_tri);
      s1_last_r <= last;
    end
  end

  // color conversion
  logic signed [9:0] c_s, d_s, e_s;
  csum_t             cy, r_sum, g_sum, b_sum;

  always_comb begin
    c_s   = $signed({2'b00, s1_y_r}) - OFS_Y;
    d_s   = $signed({2'b00, s1_u_r}) - OFS_C;
    e_s   = $signed({2'b00, s1_v_r}) - OFS_C;
    cy    = csum_t'(c_s) * K_Y;
    r_sum = cy + csum_t'(e_s) * K_RV;
    g_sum = cy - csum_t'(d_s) * K_GU - csum_t'(e_s) * K_GV;
    b_sum = cy + csum_t'(d_s) * K_BU;
  end

  // result register
  logic [47:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= {s1_row_r, s1_col_r, to_byte(b_sum), to_byte(g_sum), to_byte(r_sum)};
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready)
    else $error("input accepted while step sizes are being computed");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline is full and stalled");

  a_col_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (cr < tw_r) && (rr < th_r))
    else $error("step remainder not below target size");

  a_sel_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && sel) |=> s1_valid_r)
    else $error("selected pixel lost before conversion stage");

endmodule

// ----- hdl/yuvrgb_div.sv -----
// ----------------------------------------------------------------------------
// yuvrgb_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module yuvrgb_div #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNTW = $clog2(W + 1);

  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic [W-1:0]    quo_r;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    dvs_r;
  logic [W:0]      shifted;
  logic            fits;
  logic [W:0]      diff;

  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    fits    = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(W);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= cnt_r != CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], fits};
      rem_r <= fits ? diff[W-1:0] : shifted[W-1:0];
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
